### rtl/ssfe_pkg.sv
package ssfe_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [13:0] display_value;
        logic        colon_on;
    } t_req;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
        logic       last_byte;
    } t_rsp;

    // Four BCD digits, most significant in slot 0
    typedef struct packed {
        logic [3:0][3:0] digs;
        logic            colon;
    } t_digits;

    localparam logic [13:0] MAX_SHOWN   = 14'd9999;
    localparam logic [13:0] W_THOUSAND  = 14'd1000;
    localparam logic [13:0] W_HUNDRED   = 14'd100;
    localparam logic [13:0] W_TEN       = 14'd10;

    localparam logic [7:0] CMD_DATA    = 8'h40;
    localparam logic [7:0] CMD_ADDR    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY = 8'h80;
    localparam logic [7:0] DISPLAY_ON  = 8'h08;
    localparam logic [7:0] COLON_BIT   = 8'h80;

    // Byte slots within one request
    localparam logic [2:0] SLOT_DATA  = 3'd0;
    localparam logic [2:0] SLOT_ADDR  = 3'd1;
    localparam logic [2:0] SLOT_DIG0  = 3'd2;
    localparam logic [2:0] SLOT_DIG1  = 3'd3;
    localparam logic [2:0] SLOT_DIG2  = 3'd4;
    localparam logic [2:0] SLOT_DIG3  = 3'd5;
    localparam logic [2:0] SLOT_DISP  = 3'd6;

    // Digit of v at weight w, with v below ten times w
    function automatic logic [3:0] digit_at(input logic [13:0] v, input logic [13:0] w);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 14'(k) * w) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    function automatic logic [7:0] seg_map(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

### rtl/ssfe_digit_pipe.sv
module ssfe_digit_pipe
    import ssfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_req    i_req,
    output logic    o_valid,
    input  logic    i_ready,
    output t_digits o_dig
);

    logic        r_v1, r_v2, r_v3;
    logic        en1, en2, en3;

    logic [3:0]  r_th1;
    logic [9:0]  r_rem1;
    logic        r_col1;

    logic [3:0]  r_th2, r_hu2;
    logic [6:0]  r_rem2;
    logic        r_col2;

    t_digits     r_dig3;

    logic [13:0] sat_v;
    logic [3:0]  n_th, n_hu, n_te;
    logic [13:0] rem1_full, rem2_full, one_full;

    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    // Stage 1: saturate, thousands digit
    always_comb begin
        sat_v     = (i_req.display_value > MAX_SHOWN) ? MAX_SHOWN : i_req.display_value;
        n_th      = digit_at(sat_v, W_THOUSAND);
        rem1_full = sat_v - 14'(n_th) * W_THOUSAND;
    end

    // Stage 2: hundreds digit
    always_comb begin
        n_hu      = digit_at(14'(r_rem1), W_HUNDRED);
        rem2_full = 14'(r_rem1) - 14'(n_hu) * W_HUNDRED;
    end

    // Stage 3: tens and ones
    always_comb begin
        n_te     = digit_at(14'(r_rem2), W_TEN);
        one_full = 14'(r_rem2) - 14'(n_te) * W_TEN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_th1  <= n_th;
            r_rem1 <= rem1_full[9:0];
            r_col1 <= i_req.colon_on;
        end
        if (en2) begin
            r_th2  <= r_th1;
            r_hu2  <= n_hu;
            r_rem2 <= rem2_full[6:0];
            r_col2 <= r_col1;
        end
        if (en3) begin
            r_dig3.digs[0] <= r_th2;
            r_dig3.digs[1] <= r_hu2;
            r_dig3.digs[2] <= n_te;
            r_dig3.digs[3] <= one_full[3:0];
            r_dig3.colon   <= r_col2;
        end
    end

    assign o_valid = r_v3;
    assign o_dig   = r_dig3;

endmodule

### rtl/ssfe_frame_ser.sv
module ssfe_frame_ser
    import ssfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_digits    i_dig,
    input  logic [2:0] i_brightness,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp
);

    logic       r_hv;
    t_digits    r_hold;
    logic [2:0] r_idx;
    logic       r_ov;
    t_rsp       r_out;

    logic       out_en, take, at_last, load;
    t_rsp       n_out;

    assign out_en  = !r_ov || i_ready;
    assign take    = r_hv && out_en;
    assign at_last = (r_idx == SLOT_DISP);
    assign o_ready = !r_hv || (take && at_last);
    assign load    = i_valid && o_ready;

    always_comb begin
        n_out = '0;
        unique case (r_idx)
            SLOT_DATA: begin
                n_out.bus_byte     = CMD_DATA;
                n_out.start_before = 1'b1;
                n_out.stop_after   = 1'b1;
            end
            SLOT_ADDR: begin
                n_out.bus_byte     = CMD_ADDR;
                n_out.start_before = 1'b1;
            end
            SLOT_DIG0: n_out.bus_byte = seg_map(r_hold.digs[0]);
            SLOT_DIG1: n_out.bus_byte = seg_map(r_hold.digs[1])
                                        | (r_hold.colon ? COLON_BIT : 8'h00);
            SLOT_DIG2: n_out.bus_byte = seg_map(r_hold.digs[2]);
            SLOT_DIG3: begin
                n_out.bus_byte   = seg_map(r_hold.digs[3]);
                n_out.stop_after = 1'b1;
            end
            SLOT_DISP: begin
                n_out.bus_byte     = CMD_DISPLAY | DISPLAY_ON | {5'd0, i_brightness};
                n_out.start_before = 1'b1;
                n_out.stop_after   = 1'b1;
                n_out.last_byte    = 1'b1;
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_idx <= SLOT_DATA;
            r_ov  <= 1'b0;
        end else begin
            if (take) begin
                r_idx <= at_last ? SLOT_DATA : r_idx + 3'd1;
                r_hv  <= !at_last;
            end
            if (load) begin
                r_hv <= 1'b1;
            end
            if (out_en) begin
                r_ov <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_hold <= i_dig;
        if (take) r_out  <= n_out;
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_out;

endmodule

### rtl/seven_segment_frame_encoder.sv
// Seven-segment frame encoder for a four-digit two-wire display driver.
//
// Request channel (i_req_valid / o_req_ready / i_req): one display request
// carries a 14-bit value and a colon flag. Values above 9999 show as 9999.
// Response channel (o_rsp_valid / i_rsp_ready / o_rsp): every request yields
// seven bus bytes in order: data command, address, four segment bytes,
// display-on command. Each byte carries its start/stop framing, and the
// seventh is marked last_byte.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
// 3-bit brightness level, reset value 7; always ready. Write it only idle.
//
// The first byte of a request passes the three digit-split stages, a hold buffer
// and the output register before it appears.
// Throughput: one byte per cycle while the receiver is ready, set by the output
// port's single byte per cycle. Up to four requests queue in the digit pipeline
// and hold buffer while bytes drain.
// Reset (synchronous, active low) empties all stages and restores brightness.
// A stalled receiver holds the output byte; backpressure stops the pipeline
// stage by stage with nothing dropped or repeated.
module seven_segment_frame_encoder
    import ssfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    logic       r_brightness;
    logic [2:0] r_bright;
    logic       dig_valid, dig_ready;
    t_digits    dig;

    // Brightness register: always accept writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright     <= 3'd7;
            r_brightness <= 1'b0;
        end else if (i_cfg_valid) begin
            r_bright     <= i_cfg_data;
            r_brightness <= 1'b1;
        end
    end

    // Split the saturated value into four digits over three stages
    ssfe_digit_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .o_valid (dig_valid),
        .i_ready (dig_ready),
        .o_dig   (dig)
    );

    // Hold one request and stream its seven framed bytes
    ssfe_frame_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dig_valid),
        .o_ready      (dig_ready),
        .i_dig        (dig),
        .i_brightness (r_bright),
        .o_valid      (o_rsp_valid),
        .i_ready      (i_rsp_ready),
        .o_rsp        (o_rsp)
    );

    // Within a request, bytes follow back to back once the receiver takes one
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_ready && !o_rsp.last_byte |=> o_rsp_valid)
        else $error("response burst broke before last byte");

    // The last byte is always the display command, framed on both sides
    a_last_is_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.last_byte |->
            o_rsp.start_before && o_rsp.stop_after && o_rsp.bus_byte[7:3] == 5'b10001)
        else $error("last byte is not a framed display command");

    // A response starting a frame without stopping it is the address command
    a_open_frame_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.start_before && !o_rsp.stop_after |->
            o_rsp.bus_byte == CMD_ADDR)
        else $error("open frame without address command");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    // Config write lands in the brightness register
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_brightness && r_bright == $past(i_cfg_data))
        else $error("brightness write lost");

endmodule
